### rtl/sgb_pkg.sv
// Shared types and constants for the separable 5x5 blur.
// Used by sgb_tap5 and separable_gaussian_blur_5x5; no dependencies.
`timescale 1ns / 1ps

package sgb_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WID_W      = COL_W + 1;
	localparam int HGT_W      = ROW_W + 1;
	localparam int MIN_DIM    = 5;

	localparam int PIX_W  = 16;
	localparam int COEF_W = 8;
	localparam int PAIR_W = PIX_W + 1;
	localparam int PRD_W  = PAIR_W + COEF_W;
	localparam int SUM_W  = PRD_W + 2;

	// Division by 17 as a multiply by a rounded-up reciprocal; exact for SUM_W-bit sums
	localparam longint DIVISOR     = 17;
	localparam int     RECIP_SHIFT = 32;
	localparam int     RECIP_W     = 28;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);
	localparam int     QUO_W       = SUM_W + RECIP_W - RECIP_SHIFT;
	localparam logic [PIX_W-1:0] SAT_MAX = '1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = HGT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_OUTER,
		CFG_COEF_NEAR,
		CFG_COEF_CENTER,
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT
	} cfg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_last;
	} pix_out_t;

	// Stage loads of one five-tap filter pipeline
	typedef struct packed {
		logic prod;
		logic sum;
		logic quo;
		logic res;
	} tap_ld_t;

endpackage

### rtl/sgb_tap5.sv
// Four-stage symmetric five-tap filter: weight, sum, divide by 17, saturate.
// Depends on sgb_pkg; stage loads come from the owning pipeline.
`timescale 1ns / 1ps

module sgb_tap5 (
	input  logic                         clk,
	input  sgb_pkg::tap_ld_t             ld,
	input  logic [sgb_pkg::PAIR_W-1:0]   sum_outer,
	input  logic [sgb_pkg::PAIR_W-1:0]   sum_near,
	input  logic [sgb_pkg::PIX_W-1:0]    center,
	input  logic [sgb_pkg::COEF_W-1:0]   coef_outer,
	input  logic [sgb_pkg::COEF_W-1:0]   coef_near,
	input  logic [sgb_pkg::COEF_W-1:0]   coef_center,
	output logic [sgb_pkg::PIX_W-1:0]    result
);
	import sgb_pkg::*;

	logic [PRD_W-1:0]          prd_o_s1, prd_n_s1, prd_c_s1;
	logic [SUM_W-1:0]          sum_s2;
	logic [QUO_W-1:0]          quo_s3;
	logic [PIX_W-1:0]          res_s4;
	logic [SUM_W+RECIP_W-1:0]  recip_prod;

	assign recip_prod = {{RECIP_W{1'b0}}, sum_s2} * {{SUM_W{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (ld.prod) begin
			prd_o_s1 <= PRD_W'(sum_outer) * PRD_W'(coef_outer);
			prd_n_s1 <= PRD_W'(sum_near) * PRD_W'(coef_near);
			prd_c_s1 <= PRD_W'(center) * PRD_W'(coef_center);
		end
		if (ld.sum) begin
			sum_s2 <= SUM_W'(prd_o_s1) + SUM_W'(prd_n_s1) + SUM_W'(prd_c_s1);
		end
		if (ld.quo) begin
			quo_s3 <= recip_prod[SUM_W+RECIP_W-1:RECIP_SHIFT];
		end
		if (ld.res) begin
			res_s4 <= (quo_s3 > QUO_W'(SAT_MAX)) ? SAT_MAX : quo_s3[PIX_W-1:0];
		end
	end

	assign result = res_s4;

endmodule

### rtl/separable_gaussian_blur_5x5.sv
// Separable 5x5 blur: 11 stages from input transaction to result valid. Throughput one pixel
// per cycle unless the input stalls; each pixel in column 4 and up does one read and one lane
// write of the column store (512 x 4 x 16 bits, one port, read-first) in stage 6.
// Input stalls only while all 11 stages are full and the result is not taken.
// Reset clears counters, row window, pipeline valids and registers to defaults;
// the column store is not cleared and needs no clearing pass.
// Depends on sgb_pkg and sgb_tap5.
`timescale 1ns / 1ps

module separable_gaussian_blur_5x5 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  sgb_pkg::pix_in_t              pix_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output sgb_pkg::pix_out_t             res_data,
	input  logic                          cfg_we,
	input  logic [sgb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sgb_pkg::*;

	localparam int NSTG = 11;

	typedef struct packed {
		logic             do_out;
		logic             last;
		logic [COL_W-1:0] col;
		logic [1:0]       lane;
	} ctl_t;

	// configuration
	logic [COEF_W-1:0] coef_outer_q, coef_near_q, coef_center_q;
	logic [WID_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;

	// position and row window
	logic [COL_W-1:0]  col_cnt_q;
	logic [ROW_W-1:0]  row_cnt_q;
	logic [PIX_W-1:0]  win_q [4];

	// pipeline control
	logic [NSTG:1]     vld_q;
	logic [NSTG+1:1]   rdy;
	logic [NSTG:1]     vin;
	logic [NSTG:1]     ld;

	logic              pix_acc;
	logic [COL_W-1:0]  c_cur;
	logic [ROW_W-1:0]  r_cur;
	logic [WID_W-1:0]  c_nxt;
	logic [HGT_W-1:0]  r_nxt;
	logic              do_mem, wrap_col, wrap_row;
	ctl_t              ctl_new;

	// payload
	logic [PAIR_W-1:0] sa_s1, sb_s1;
	logic [PIX_W-1:0]  sc_s1;
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [PIX_W-1:0]  mid;
	logic [3:0][PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [3:0][PIX_W-1:0] rd_s6;
	logic [PIX_W-1:0]  mid_s6;
	ctl_t              ctl_s6;
	logic [PAIR_W-1:0] sa_s7, sb_s7;
	logic [PIX_W-1:0]  sc_s7;
	logic [NSTG:7]     last_q;
	logic [PIX_W-1:0]  blur;
	tap_ld_t           ld_row, ld_col;

	// configuration writes; image dimensions are clamped on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_outer_q  <= COEF_W'(1);
			coef_near_q   <= COEF_W'(4);
			coef_center_q <= COEF_W'(7);
			width_q       <= WID_W'(MAX_WIDTH);
			height_q      <= HGT_W'(512);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_COEF_OUTER:  coef_outer_q  <= cfg_data[COEF_W-1:0];
				CFG_COEF_NEAR:   coef_near_q   <= cfg_data[COEF_W-1:0];
				CFG_COEF_CENTER: coef_center_q <= cfg_data[COEF_W-1:0];
				CFG_IMAGE_WIDTH: begin
					if (cfg_data[9:0] < 10'(MIN_DIM))
						width_q <= WID_W'(MIN_DIM);
					else if (cfg_data[9:0] > 10'(MAX_WIDTH))
						width_q <= WID_W'(MAX_WIDTH);
					else
						width_q <= WID_W'(cfg_data[9:0]);
				end
				CFG_IMAGE_HEIGHT: begin
					if (cfg_data < CFG_DATA_W'(MIN_DIM))
						height_q <= HGT_W'(MIN_DIM);
					else if (cfg_data > CFG_DATA_W'(MAX_HEIGHT))
						height_q <= HGT_W'(MAX_HEIGHT);
					else
						height_q <= HGT_W'(cfg_data);
				end
				default: ;
			endcase
		end
	end

	// position of the incoming pixel
	always_comb begin
		c_cur    = pix_data.frame_start ? '0 : col_cnt_q;
		r_cur    = pix_data.frame_start ? '0 : row_cnt_q;
		c_nxt    = WID_W'(c_cur) + WID_W'(1);
		r_nxt    = HGT_W'(r_cur) + HGT_W'(1);
		wrap_col = c_nxt >= width_q;
		wrap_row = r_nxt >= height_q;
		do_mem   = (c_cur >= COL_W'(4)) && (WID_W'(c_cur) < width_q);
		ctl_new.do_out = do_mem && (r_cur >= ROW_W'(4)) && (HGT_W'(r_cur) < height_q);
		ctl_new.last   = (r_nxt == height_q) && (c_nxt == width_q);
		ctl_new.col    = c_cur - COL_W'(2);
		ctl_new.lane   = r_cur[1:0];
	end

	// stage handshakes: a stage takes a new item when empty or being drained
	always_comb begin
		rdy[NSTG+1] = res_ready;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		vin[1] = pix_valid && do_mem;
		for (int k = 2; k <= NSTG; k++) begin
			vin[k] = vld_q[k-1];
		end
		// drop items that only update the store
		vin[7] = vld_q[6] && ctl_s6.do_out;
		ld = vin & rdy[NSTG:1];
	end

	assign pix_ready = rdy[1];
	assign pix_acc   = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			for (int i = 0; i < 4; i++) win_q[i] <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (rdy[k]) vld_q[k] <= vin[k];
			end
			if (pix_acc) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= pix_data.pixel_in;
				if (wrap_col) begin
					col_cnt_q <= '0;
					row_cnt_q <= wrap_row ? '0 : r_nxt[ROW_W-1:0];
				end else begin
					col_cnt_q <= c_nxt[COL_W-1:0];
					row_cnt_q <= r_cur;
				end
			end
		end
	end

	// stage 1: horizontal tap pairs
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			sa_s1  <= PAIR_W'(win_q[0]) + PAIR_W'(pix_data.pixel_in);
			sb_s1  <= PAIR_W'(win_q[1]) + PAIR_W'(win_q[3]);
			sc_s1  <= win_q[2];
			ctl_s1 <= ctl_new;
		end
		if (ld[2]) ctl_s2 <= ctl_s1;
		if (ld[3]) ctl_s3 <= ctl_s2;
		if (ld[4]) ctl_s4 <= ctl_s3;
		if (ld[5]) ctl_s5 <= ctl_s4;
	end

	assign ld_row = '{prod: ld[2], sum: ld[3], quo: ld[4], res: ld[5]};

	sgb_tap5 u_row_tap (
		.clk         (clk),
		.ld          (ld_row),
		.sum_outer   (sa_s1),
		.sum_near    (sb_s1),
		.center      (sc_s1),
		.coef_outer  (coef_outer_q),
		.coef_near   (coef_near_q),
		.coef_center (coef_center_q),
		.result      (mid)
	);

	// stage 6: read the column's four lines, replace the oldest with this row
	always_ff @(posedge clk) begin
		if (ld[6]) begin
			rd_s6                                <= line_mem[ctl_s5.col];
			line_mem[ctl_s5.col][ctl_s5.lane]    <= mid;
			mid_s6                               <= mid;
			ctl_s6                               <= ctl_s5;
		end
	end

	// stage 7: vertical tap pairs, oldest line sits in the lane being replaced
	always_ff @(posedge clk) begin
		if (ld[7]) begin
			sa_s7     <= PAIR_W'(rd_s6[ctl_s6.lane]) + PAIR_W'(mid_s6);
			sb_s7     <= PAIR_W'(rd_s6[ctl_s6.lane + 2'd1]) +
			             PAIR_W'(rd_s6[ctl_s6.lane + 2'd3]);
			sc_s7     <= rd_s6[ctl_s6.lane + 2'd2];
			last_q[7] <= ctl_s6.last;
		end
		for (int k = 8; k <= NSTG; k++) begin
			if (ld[k]) last_q[k] <= last_q[k-1];
		end
	end

	assign ld_col = '{prod: ld[8], sum: ld[9], quo: ld[10], res: ld[11]};

	sgb_tap5 u_col_tap (
		.clk         (clk),
		.ld          (ld_col),
		.sum_outer   (sa_s7),
		.sum_near    (sb_s7),
		.center      (sc_s7),
		.coef_outer  (coef_outer_q),
		.coef_near   (coef_near_q),
		.coef_center (coef_center_q),
		.result      (blur)
	);

	assign res_valid          = vld_q[NSTG];
	assign res_data.pixel_out = blur;
	assign res_data.frame_last = last_q[NSTG];

	// frame end returns the position to the origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && wrap_col && wrap_row |=> col_cnt_q == '0 && row_cnt_q == '0)
		else $error("position not cleared after last pixel of frame");

	// clamped dimensions stay inside the supported range
	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		width_q >= WID_W'(MIN_DIM) && width_q <= WID_W'(MAX_WIDTH) &&
		height_q >= HGT_W'(MIN_DIM) && height_q <= HGT_W'(MAX_HEIGHT))
		else $error("frame dimension out of range");

	// input stalls only when every stage holds a transaction and the output is blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> &vld_q && !res_ready)
		else $error("input stalled with room in the pipeline");

	// a stalled result stays valid at the output with its frame_last flag unchanged
	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG] && !res_ready |=> vld_q[NSTG] && $stable(last_q[NSTG]))
		else $error("stalled result lost");

endmodule
